[rtl/core/tftsc_pkg.sv]
// Shared constants, types and code values for the text frame tokenizer.
// Used by tftsc_token, tftsc_frame and text_frame_tokenizer_with_sum_check.
package tftsc_pkg;

  // Frame size limit and the counter width that covers FRAME_LIMIT-1
  localparam int FRAME_LIMIT = 512;
  localparam int CNT_W       = $clog2(FRAME_LIMIT);

  // Trailer word "Checksum"
  localparam int TRAILER_LEN = 8;
  localparam int MATCH_W     = $clog2(TRAILER_LEN);
  localparam logic [7:0] TRAILER [TRAILER_LEN] = '{
    8'h43, 8'h68, 8'h65, 8'h63, 8'h6B, 8'h73, 8'h75, 8'h6D
  };

  // Bytes that follow the trailer, the last of them ends the frame
  localparam int TAIL_W = 2;
  localparam logic [TAIL_W-1:0] TAIL_BYTES = TAIL_W'(2);

  // Leading frame bytes that bypass the tokenizer
  localparam logic [CNT_W-1:0] SKIP_BYTES = CNT_W'(2);

  // Special characters
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Byte role codes
  typedef logic [1:0] role_t;
  localparam role_t ROLE_SKIP  = 2'd0;
  localparam role_t ROLE_LABEL = 2'd1;
  localparam role_t ROLE_VALUE = 2'd2;

  // Frame tracker to tokenizer control
  typedef struct packed {
    logic step;     // a word moves through this cycle
    logic active;   // word is past the skipped head and not dropped
    logic restart;  // frame ends or restarts on this word
  } tok_ctl_t;

  // Tokenizer to frame tracker status
  typedef struct packed {
    role_t role;
    logic  pair;        // newline closed a line holding a value
    logic  value_seen;  // line holds a value after this word
  } tok_res_t;

  // One result word
  typedef struct packed {
    logic [7:0] echo_byte;
    role_t      role;
    logic       pair_done;
    logic       frame_done;
    logic       frame_ok;
    logic       overflow;
  } res_t;

endpackage

[rtl/core/tftsc_token.sv]
// Label/value tokenizer: line phase and value flag per received word.
// Depends on tftsc_pkg for character codes, role codes and control structs.
module tftsc_token import tftsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tok_ctl_t   ctl_i,
  input  logic [7:0] byte_i,
  output tok_res_t   res_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_LABEL = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;
  localparam logic [1:0] PH_VALUE = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic       value_seen_q, value_seen_d;

  // Classify the word and advance the line phase
  always_comb begin
    phase_d      = phase_q;
    value_seen_d = value_seen_q;
    res_o.role   = ROLE_SKIP;
    res_o.pair   = 1'b0;
    if (ctl_i.active) begin
      if (byte_i == CH_NL) begin
        res_o.pair   = value_seen_q;
        phase_d      = PH_IDLE;
        value_seen_d = 1'b0;
      end else if (byte_i inside {CH_TAB, CH_CR}) begin
        if (phase_q inside {PH_LABEL, PH_VALUE}) begin
          phase_d = PH_GAP;
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
            phase_d    = PH_LABEL;
            res_o.role = ROLE_LABEL;
          end
          PH_LABEL: begin
            res_o.role = ROLE_LABEL;
          end
          PH_GAP: begin
            if (!value_seen_q) begin
              phase_d      = PH_VALUE;
              value_seen_d = 1'b1;
              res_o.role   = ROLE_VALUE;
            end
          end
          PH_VALUE: begin
            res_o.role = ROLE_VALUE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
    res_o.value_seen = value_seen_d;
    // Drop line state when the frame ends or restarts
    if (ctl_i.restart) begin
      phase_d      = PH_IDLE;
      value_seen_d = 1'b0;
    end
  end

  // Hold line state between words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      value_seen_q <= 1'b0;
    end else if (ctl_i.step) begin
      phase_q      <= phase_d;
      value_seen_q <= value_seen_d;
    end
  end

endmodule

[rtl/core/tftsc_frame.sv]
// Frame tracker: byte count, modulo-256 sum, trailer matcher and tail count.
// Depends on tftsc_pkg; instantiates tftsc_token for the per-word roles.
module tftsc_frame import tftsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       check_en_i,
  output res_t       res_o
);

  logic [CNT_W-1:0]   count_q, count_d;
  logic [7:0]         sum_q, sum_d;
  logic [MATCH_W-1:0] match_q, match_d;
  logic               ending_q, ending_d;
  logic [TAIL_W-1:0]  tail_q, tail_d;

  logic               ovf;
  logic               hit;
  logic               done;
  logic [7:0]         sum_next;
  logic [MATCH_W:0]   match_inc;
  tok_ctl_t           tok_ctl;
  tok_res_t           tok_res;

  assign ovf      = (count_q >= CNT_W'(FRAME_LIMIT - 1));
  assign sum_next = sum_q + byte_i;

  // Update count, sum, trailer match and tail for one word
  always_comb begin
    count_d   = count_q + 1'b1;
    sum_d     = sum_next;
    ending_d  = ending_q;
    tail_d    = tail_q;
    done      = 1'b0;
    hit       = 1'b0;
    match_inc = {1'b0, match_q} + 1'b1;
    if (byte_i == TRAILER[match_q]) begin
      if (match_inc == (MATCH_W+1)'(TRAILER_LEN)) begin
        match_d = '0;
        hit     = 1'b1;
      end else begin
        match_d = match_inc[MATCH_W-1:0];
      end
    end else begin
      match_d = (byte_i == TRAILER[0]) ? MATCH_W'(1) : '0;
    end
    if (hit) begin
      ending_d = 1'b1;
    end else if (ending_q) begin
      tail_d = tail_q - 1'b1;
      done   = (tail_d == '0);
    end
    // Restart the frame on its final word or on a dropped word
    if (ovf || done) begin
      count_d  = '0;
      sum_d    = '0;
      match_d  = '0;
      ending_d = 1'b0;
      tail_d   = TAIL_BYTES;
    end
  end

  assign tok_ctl.step    = step_i;
  assign tok_ctl.active  = !ovf && (count_q >= SKIP_BYTES);
  assign tok_ctl.restart = (ovf || done);

  tftsc_token u_token (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (tok_ctl),
    .byte_i (byte_i),
    .res_o  (tok_res)
  );

  // Assemble the result word
  always_comb begin
    res_o.echo_byte  = byte_i;
    res_o.role       = tok_res.role;
    res_o.pair_done  = tok_res.pair || (!ovf && done && tok_res.value_seen);
    res_o.frame_done = !ovf && done;
    res_o.frame_ok   = !ovf && done && (!check_en_i || (sum_next == 8'h00));
    res_o.overflow   = ovf;
  end

  // Hold frame state between words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      match_q  <= '0;
      ending_q <= 1'b0;
      tail_q   <= TAIL_BYTES;
    end else if (step_i) begin
      count_q  <= count_d;
      sum_q    <= sum_d;
      match_q  <= match_d;
      ending_q <= ending_d;
      tail_q   <= tail_d;
    end
  end

  // Final word leaves a fresh frame behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.frame_done |=> count_q == '0 && !ending_q && tail_q == TAIL_BYTES)
    else $error("frame state not cleared after final word");

  // Tail count only moves once the trailer is seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ending_q |-> tail_q == TAIL_BYTES)
    else $error("tail count moved before trailer");

  // A dropped word starts the frame over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ovf |=> count_q == '0 && sum_q == '0 && !ending_q)
    else $error("frame state not cleared after dropped word");

endmodule

[rtl/core/text_frame_tokenizer_with_sum_check.sv]
// Top level of the text frame tokenizer: input register, frame tracker, result register.
// Depends on tftsc_pkg and tftsc_frame.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, rx_byte_i) takes one received byte per word.
//   Output channel (out_valid_o, out_stall_i, result fields) gives one result word per
//   input word, in order: the echoed byte, its token role, pair_done, frame_done,
//   frame_ok and overflow.
//   Configuration channel (cfg_valid_i, cfg_ready_o, cfg_check_enable_i) writes the
//   check enable bit; cfg_ready_o is always high. Write it only while the block is idle.
// Path: a word accepted into the input register passes through the frame tracker into
//   the result register, which drives the output.
// Throughput: one word per cycle unless out_stall_i holds; the frame state update is
//   a single pass between the input and result registers, so words follow back to back.
// Reset: frame state clears, check enable returns to 1, both valid flags drop.
// Stall: while out_stall_i holds a waiting result, the input register still fills once;
//   after that in_stall_o rises until the result is taken. Nothing is lost.
module text_frame_tokenizer_with_sum_check import tftsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] echo_byte_o,
  output logic [1:0] role_o,
  output logic       pair_done_o,
  output logic       frame_done_o,
  output logic       frame_ok_o,
  output logic       overflow_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_check_enable_i
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  res_t       res_q, res_d;
  logic       check_en_q;
  logic       out_load;
  logic       in_move;
  logic       in_accept;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_move    = in_valid_q && out_load;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Capture the check enable bit
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      check_en_q <= cfg_check_enable_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (in_move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  tftsc_frame u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_move),
    .byte_i     (in_byte_q),
    .check_en_i (check_en_q),
    .res_o      (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign echo_byte_o  = res_q.echo_byte;
  assign role_o       = res_q.role;
  assign pair_done_o  = res_q.pair_done;
  assign frame_done_o = res_q.frame_done;
  assign frame_ok_o   = res_q.frame_ok;
  assign overflow_o   = res_q.overflow;

  // A dropped word never ends a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> !frame_done_o && !pair_done_o && role_o == ROLE_SKIP)
    else $error("dropped word carries frame or token flags");

  // Acceptance is reported only on the final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ok_o |-> frame_done_o)
    else $error("frame_ok without frame_done");

  // With checking off, every finished frame is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o && !check_en_q |-> frame_ok_o)
    else $error("frame rejected with checking disabled");

endmodule
